@@ rtl/lmln_pkg.sv @@
package lmln_pkg;

  // widest pixel the block handles, also the width of every stream field
  localparam int unsigned PIXEL_BITS_DEF = 16;
  localparam int unsigned FIELD_W        = 16;

  // stream bus widths
  localparam int unsigned IN_DATA_W  = 4 * FIELD_W;
  localparam int unsigned OUT_DATA_W = FIELD_W;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_MIN_RANGE = 2'd0;
  localparam logic [FIELD_W-1:0]    MIN_RANGE_RST  = 16'd1;

endpackage

@@ rtl/local_minmax_luma_normalize.sv @@
// local min/max luma normalizer
//
// in channel: one transaction per pixel, in_tdata carries luma_in, env_low,
// env_high and env_mid (16 bits each, lowest first). out channel: one
// transaction per pixel, out_tdata carries luma_out. exactly one result per
// input, in order.
//
// the envelopes are widened to contain the midpoint, made symmetric about it,
// grown to min_range where too narrow, and the luma is rescaled into the
// resulting window with saturation to 0..2^PIXEL_BITS-1.
//
// the path from input transaction to out_tvalid has six stages of window
// arithmetic, one restoring-divider stage per quotient bit, then the output
// register. throughput is one pixel per clock while the output is not stalled,
// set by the divider having a stage of its own for every quotient bit.
//
// stalls: each stage holds its data while the next one is full and stalled;
// empty stages keep filling, so input is taken while a result waits, until
// every stage is occupied. nothing is dropped or repeated. reset (synchronous,
// rst_n low) empties the pipeline and sets min_range to 1. the user must write
// min_range through the apb port only while the block is idle, unenforced.
module local_minmax_luma_normalize #(
  parameter int unsigned PIXEL_BITS = lmln_pkg::PIXEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input pixel stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [15:0] luma_in, [31:16] env_low, [47:32] env_high, [63:48] env_mid
  input  logic [lmln_pkg::IN_DATA_W-1:0]       in_tdata,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] luma_out
  output logic [lmln_pkg::OUT_DATA_W-1:0]      out_tdata,
  // configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [lmln_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [lmln_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [lmln_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int unsigned PB = PIXEL_BITS;
  localparam int unsigned FW = lmln_pkg::FIELD_W;
  localparam logic [PB-1:0] FULL = '1;

  // stage map: six window stages, PB divider steps, output register
  localparam int unsigned ST_S1   = 0;
  localparam int unsigned ST_S2   = 1;
  localparam int unsigned ST_S3   = 2;
  localparam int unsigned ST_S4   = 3;
  localparam int unsigned ST_S5   = 4;
  localparam int unsigned ST_S6   = 5;
  localparam int unsigned ST_DIV0 = 6;
  localparam int unsigned NS      = 7 + PB;
  localparam int unsigned ST_OUT  = NS - 1;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [FW-1:0] min_range_r;
  logic [PB-1:0] floor_r;      // min_range clamped to 1..FULL
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == lmln_pkg::ADDR_MIN_RANGE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= lmln_pkg::MIN_RANGE_RST;
      floor_r     <= PB'(1);
    end else begin
      if (cfg_wr) begin
        min_range_r <= cfg_pwdata[FW-1:0];
      end
      // zero acts as one, anything above full scale acts as full scale
      priority if (min_range_r == '0) begin
        floor_r <= PB'(1);
      end else if (min_range_r > FW'(FULL)) begin
        floor_r <= FULL;
      end else begin
        floor_r <= min_range_r[PB-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == lmln_pkg::ADDR_MIN_RANGE) begin
      cfg_prdata = lmln_pkg::CFG_DATA_W'(min_range_r);
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: per-stage valid, a stage loads when empty or draining
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready  = en[ST_S1];
  assign out_tvalid = v_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // s1: take the low pixel bits of each field, widen envelopes to the midpoint
  // ---------------------------------------------------------------------------
  logic [PB-1:0] in_pix, in_lo, in_hi, in_mid;
  logic [PB-1:0] s1_pix_r, s1_lo_r, s1_hi_r, s1_mid_r;

  assign in_pix = in_tdata[0*FW +: PB];
  assign in_lo  = in_tdata[1*FW +: PB];
  assign in_hi  = in_tdata[2*FW +: PB];
  assign in_mid = in_tdata[3*FW +: PB];

  always_ff @(posedge clk) begin
    if (en[ST_S1]) begin
      s1_pix_r <= in_pix;
      s1_mid_r <= in_mid;
      s1_lo_r  <= (in_lo > in_mid) ? in_mid : in_lo;
      s1_hi_r  <= (in_hi < in_mid) ? in_mid : in_hi;
    end
  end

  // ---------------------------------------------------------------------------
  // s2: mirror the nearer side from the farther one, clamp to 0..FULL
  // ---------------------------------------------------------------------------
  logic [PB-1:0]        s2_dh, s2_dl;
  logic [PB:0]          s2_twice;
  logic signed [PB+1:0] s2_lo_cand;
  logic [PB:0]          s2_hi_cand;
  logic [PB-1:0]        s2_lo_nxt, s2_hi_nxt;
  logic [PB-1:0]        s2_pix_r, s2_lo_r, s2_hi_r;

  always_comb begin
    s2_dh      = s1_hi_r - s1_mid_r;
    s2_dl      = s1_mid_r - s1_lo_r;
    s2_twice   = {s1_mid_r, 1'b0};
    s2_lo_cand = $signed({1'b0, s2_twice}) - $signed({2'b0, s1_hi_r});
    s2_hi_cand = s2_twice - {1'b0, s1_lo_r};
    s2_lo_nxt  = s1_lo_r;
    s2_hi_nxt  = s1_hi_r;
    // an already symmetric window passes unchanged
    if (s2_dh > s2_dl) begin
      s2_lo_nxt = (s2_lo_cand < 0) ? '0 : s2_lo_cand[PB-1:0];
    end else if (s2_dh < s2_dl) begin
      s2_hi_nxt = (s2_hi_cand > {1'b0, FULL}) ? FULL : s2_hi_cand[PB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_S2]) begin
      s2_pix_r <= s1_pix_r;
      s2_lo_r  <= s2_lo_nxt;
      s2_hi_r  <= s2_hi_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // s3: window width
  // ---------------------------------------------------------------------------
  logic [PB-1:0] s3_pix_r, s3_lo_r, s3_width_r;

  always_ff @(posedge clk) begin
    if (en[ST_S3]) begin
      s3_pix_r   <= s2_pix_r;
      s3_lo_r    <= s2_lo_r;
      s3_width_r <= s2_hi_r - s2_lo_r;
    end
  end

  // ---------------------------------------------------------------------------
  // s4: centre of the window and the low edge of a grown window
  // ---------------------------------------------------------------------------
  logic [PB-1:0]      s4_centre;
  logic [PB-1:0]      s4_pix_r, s4_lo_r, s4_width_r;
  logic               s4_small_r;
  logic signed [PB:0] s4_nlo_r;

  assign s4_centre = s3_lo_r + (s3_width_r >> 1);

  always_ff @(posedge clk) begin
    if (en[ST_S4]) begin
      s4_pix_r   <= s3_pix_r;
      s4_lo_r    <= s3_lo_r;
      s4_width_r <= s3_width_r;
      s4_small_r <= (s3_width_r < floor_r);
      s4_nlo_r   <= $signed({1'b0, s4_centre}) - $signed({1'b0, floor_r >> 1});
    end
  end

  // ---------------------------------------------------------------------------
  // s5: slide a grown window back inside 0..FULL
  // ---------------------------------------------------------------------------
  logic [PB:0]   s5_nhi;
  logic [PB-1:0] s5_lo_nxt, s5_width_nxt;
  logic [PB-1:0] s5_pix_r, s5_lo_r, s5_width_r;

  always_comb begin
    s5_nhi       = {1'b0, s4_nlo_r[PB-1:0]} + {1'b0, floor_r};
    s5_lo_nxt    = s4_lo_r;
    s5_width_nxt = s4_width_r;
    if (s4_small_r) begin
      s5_width_nxt = floor_r;
      priority if (s4_nlo_r < 0) begin
        s5_lo_nxt = '0;
      end else if (s5_nhi > {1'b0, FULL}) begin
        s5_lo_nxt = FULL - floor_r;
      end else begin
        s5_lo_nxt = s4_nlo_r[PB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_S5]) begin
      s5_pix_r   <= s4_pix_r;
      s5_lo_r    <= s5_lo_nxt;
      s5_width_r <= s5_width_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // s6: offset into the window, dividend (offset * FULL), range flags
  // a luma at or past the top edge saturates, so the divider only ever sees
  // a dividend below width * 2^PB and needs PB quotient bits
  // ---------------------------------------------------------------------------
  logic [PB-1:0]   s6_d;
  logic [2*PB-1:0] s6_num;

  // index 0 is the s6 register, index j+1 the result of divider step j
  logic [PB-1:0] rem_r   [PB+1];
  logic [PB-1:0] numlo_r [PB+1];
  logic [PB-1:0] w_r     [PB+1];
  logic [PB-1:0] q_r     [PB+1];
  logic          under_r [PB+1];
  logic          sat_r   [PB+1];

  assign s6_d   = s5_pix_r - s5_lo_r;
  assign s6_num = {s6_d, {PB{1'b0}}} - {{PB{1'b0}}, s6_d};

  always_ff @(posedge clk) begin
    if (en[ST_S6]) begin
      rem_r[0]   <= s6_num[2*PB-1:PB];
      numlo_r[0] <= s6_num[PB-1:0];
      w_r[0]     <= s5_width_r;
      q_r[0]     <= '0;
      under_r[0] <= (s5_pix_r <= s5_lo_r);
      sat_r[0]   <= (s6_d >= s5_width_r);
    end
  end

  // ---------------------------------------------------------------------------
  // restoring divider, one quotient bit per stage
  // ---------------------------------------------------------------------------
  logic [PB-1:0] rem_nxt [PB];
  logic [PB-1:0] q_nxt   [PB];

  for (genvar j = 0; j < PB; j++) begin : g_div
    logic [PB:0] trial;
    logic        ge;

    always_comb begin
      trial      = {rem_r[j], numlo_r[j][PB-1-j]};
      ge         = (trial >= {1'b0, w_r[j]});
      rem_nxt[j] = ge ? PB'(trial - {1'b0, w_r[j]}) : trial[PB-1:0];
      q_nxt[j]   = {q_r[j][PB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV0+j]) begin
        rem_r[j+1]   <= rem_nxt[j];
        numlo_r[j+1] <= numlo_r[j];
        w_r[j+1]     <= w_r[j];
        q_r[j+1]     <= q_nxt[j];
        under_r[j+1] <= under_r[j];
        sat_r[j+1]   <= sat_r[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [PB-1:0] res_nxt;
  logic [FW-1:0] out_r;

  always_comb begin
    priority if (under_r[PB]) begin
      res_nxt = '0;
    end else if (sat_r[PB]) begin
      res_nxt = FULL;
    end else begin
      res_nxt = q_r[PB];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_r <= FW'(res_nxt);
    end
  end

  assign out_tdata = out_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // input is refused only with every stage full and the output stalled
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&v_r) && !out_tready))
    else $error("input refused while the pipeline has room");

  // the width floor is never zero, so the divisor never is
  a_floor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    floor_r != '0)
    else $error("width floor is zero");

  // the final window lies inside 0..FULL and has nonzero width
  a_window_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_S5] |-> ((s5_width_r != '0) &&
                    (({1'b0, s5_lo_r} + {1'b0, s5_width_r}) <= {1'b0, FULL})))
    else $error("window outside full scale");

  // the divider remainder stays below the divisor on in-range pixels
  a_rem_below_width: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[ST_OUT-1] && !under_r[PB] && !sat_r[PB]) |-> (rem_r[PB] < w_r[PB]))
    else $error("divider remainder not below divisor");

endmodule

@@ tb/tb_local_minmax_luma_normalize.sv @@
`timescale 1ns / 1ps

// one pixel transaction as it travels on in_tdata, luma in the lowest bits
typedef struct packed {
  logic [lmln_pkg::FIELD_W-1:0] env_mid;
  logic [lmln_pkg::FIELD_W-1:0] env_high;
  logic [lmln_pkg::FIELD_W-1:0] env_low;
  logic [lmln_pkg::FIELD_W-1:0] luma;
} pixel_t;

// keeps its own copy of min_range and the normalized luma still owed by the block
class luma_norm_checker;
  logic [lmln_pkg::FIELD_W-1:0] min_range;
  logic [lmln_pkg::FIELD_W-1:0] luma_due[$];
  int unsigned                  mismatches;

  function new();
    min_range  = lmln_pkg::MIN_RANGE_RST;
    mismatches = 0;
  endfunction

  // window arithmetic for one pixel, done in wide signed integers
  function logic [lmln_pkg::FIELD_W-1:0] normalize_luma(pixel_t px);
    longint full, pix, lo, hi, mid, skew, width, floor_w, centre, grow_lo, grow_hi, q;
    full = (longint'(1) << lmln_pkg::PIXEL_BITS_DEF) - 1;
    pix  = longint'(px.luma) & full;
    lo   = longint'(px.env_low) & full;
    hi   = longint'(px.env_high) & full;
    mid  = longint'(px.env_mid) & full;
    // envelopes must contain the midpoint
    if (lo > mid) lo = mid;
    if (hi < mid) hi = mid;
    // mirror the nearer side about the midpoint
    skew = (hi - mid) - (mid - lo);
    if (skew > 0) begin
      lo = 2 * mid - hi;
      if (lo < 0) lo = 0;
    end else if (skew < 0) begin
      hi = 2 * mid - lo;
      if (hi > full) hi = full;
    end
    // grow a narrow window around its centre, then slide it back in range
    width   = hi - lo;
    floor_w = longint'(min_range);
    if (floor_w < 1) floor_w = 1;
    if (floor_w > full) floor_w = full;
    centre = lo + width / 2;
    if (width < floor_w) begin
      width   = floor_w;
      grow_lo = centre - width / 2;
      grow_hi = grow_lo + width;
      if (grow_lo < 0) begin
        grow_hi = grow_hi - grow_lo;
        grow_lo = 0;
      end else if (grow_hi > full) begin
        grow_lo = grow_lo - (grow_hi - full);
        grow_hi = full;
      end
      lo = grow_lo;
      hi = grow_hi;
    end
    if (pix <= lo) begin
      q = 0;
    end else begin
      q = ((pix - lo) * full) / width;
      if (q > full) q = full;
    end
    return q[lmln_pkg::FIELD_W-1:0];
  endfunction

  function void take_pixel(pixel_t px);
    luma_due.push_back(normalize_luma(px));
  endfunction

  function void check_luma(logic [lmln_pkg::FIELD_W-1:0] got);
    logic [lmln_pkg::FIELD_W-1:0] want;
    if (luma_due.size() == 0) begin
      $error("luma_out: result with nothing outstanding, expected none, actual %0d", got);
      mismatches++;
    end else begin
      want = luma_due.pop_front();
      if (got !== want) begin
        $error("luma_out mismatch: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    end
  endfunction
endclass

module tb_local_minmax_luma_normalize;

  localparam int FULL         = (1 << lmln_pkg::PIXEL_BITS_DEF) - 1;
  // pipeline depth plus a little margin, used after the drains around each phase
  localparam int SETTLE_CYCLES = 7 + lmln_pkg::PIXEL_BITS_DEF + 10;
  localparam int PHASE_PIXELS  = 240;
  localparam int NUM_PHASES    = 8;

  // every block input starts at a known value
  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [lmln_pkg::IN_DATA_W-1:0]  in_tdata    = '0;
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [lmln_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [lmln_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [lmln_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [lmln_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // no idling on either side once this is set
  bit quiet = 1'b0;

  luma_norm_checker tracker = new();

  local_minmax_luma_normalize dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // [15:0] luma_in, [31:16] env_low, [47:32] env_high, [63:48] env_mid
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // [15:0] luma_out
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  // result side: backpressure in random bursts
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // every result transaction is compared with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_luma(out_tdata[lmln_pkg::FIELD_W-1:0]);
  end

  // a level biased toward both ends of the pixel range
  function automatic int any_level();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 300);
      1:       return $urandom_range(FULL - 300, FULL);
      default: return $urandom_range(0, FULL);
    endcase
  endfunction

  function automatic pixel_t pix4(int luma, int lo, int hi, int mid);
    pixel_t px;
    px.luma     = luma[lmln_pkg::FIELD_W-1:0];
    px.env_low  = lo[lmln_pkg::FIELD_W-1:0];
    px.env_high = hi[lmln_pkg::FIELD_W-1:0];
    px.env_mid  = mid[lmln_pkg::FIELD_W-1:0];
    return px;
  endfunction

  // mostly plausible envelopes around a midpoint, some pure noise
  function automatic pixel_t make_pixel();
    int mid, lo, hi, luma, reach, span_lo, span_hi, a, b;
    if ($urandom_range(0, 4) == 0)
      return pixel_t'({$urandom(), $urandom()});
    mid = any_level();
    case ($urandom_range(0, 2))
      0:       reach = 64;
      1:       reach = 4000;
      default: reach = FULL;
    endcase
    span_lo = $urandom_range(0, reach);
    span_hi = ($urandom_range(0, 2) == 0) ? span_lo : $urandom_range(0, reach);
    lo = mid - span_lo;
    if (lo < 0) lo = 0;
    hi = mid + span_hi;
    if (hi > FULL) hi = FULL;
    // envelopes that miss the midpoint
    case ($urandom_range(0, 7))
      0: begin
        lo = mid + $urandom_range(1, 500);
        if (lo > FULL) lo = FULL;
      end
      1: begin
        hi = mid - $urandom_range(1, 500);
        if (hi < 0) hi = 0;
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      luma = any_level();
    end else begin
      a = ((lo < hi) ? lo : hi) - 200;
      b = ((lo < hi) ? hi : lo) + 200;
      if (a < 0) a = 0;
      if (b > FULL) b = FULL;
      luma = $urandom_range(a, b);
    end
    return pix4(luma, lo, hi, mid);
  endfunction

  // one input transaction, then maybe a burst of idle cycles
  task automatic pass_pixel(pixel_t px);
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    tracker.take_pixel(px);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_pipe(int extra);
    in_tvalid <= 1'b0;
    while (tracker.luma_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // apb write then read back, junk in the upper data bits
  task automatic set_min_range(logic [lmln_pkg::FIELD_W-1:0] value);
    logic [lmln_pkg::CFG_DATA_W-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= lmln_pkg::ADDR_MIN_RANGE;
    cfg_pwdata  <= {16'($urandom()), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.min_range = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[lmln_pkg::FIELD_W-1:0] !== value) begin
      $error("min_range readback mismatch: expected %0d, actual %0d",
             value, rd[lmln_pkg::FIELD_W-1:0]);
      tracker.mismatches++;
    end
  endtask

  logic [lmln_pkg::FIELD_W-1:0] range_plan[NUM_PHASES];

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels at the reset width of 1
    pass_pixel(pix4(0, 0, 0, 0));                      // everything at zero
    pass_pixel(pix4(FULL, FULL, FULL, FULL));          // everything at full scale
    pass_pixel(pix4(5000, 40000, 50000, 30000));       // low envelope above midpoint
    pass_pixel(pix4(60000, 10000, 20000, 30000));      // high envelope below midpoint
    pass_pixel(pix4(30000, 900, 60000, 1000));         // mirrored low side clamps at 0
    pass_pixel(pix4(65000, 1000, 64100, 64000));       // mirrored high side clamps at full
    pass_pixel(pix4(2500, 1000, 3000, 2000));          // already symmetric
    pass_pixel(pix4(100, 1000, 3000, 2000));           // luma below window
    pass_pixel(pix4(1000, 1000, 3000, 2000));          // luma on low edge
    pass_pixel(pix4(5000, 1000, 3000, 2000));          // luma above window, saturates
    pass_pixel(pix4(3000, 1000, 3000, 2000));          // luma on high edge
    pass_pixel(pix4(6, 5, 5, 5));                      // zero width grows to minimum
    pass_pixel(pix4(1, 0, 0, 0));                      // zero width at bottom
    pass_pixel(pix4(FULL, FULL, FULL, FULL - 1));      // narrow window at top, low edge mirrored down
    pass_pixel(pix4('haaaa, 'h5555, 'haaaa, 'h8000));  // alternating bit patterns
    pass_pixel(pix4('h5555, 0, FULL, 'h7fff));         // skew of one, low clamps
    pass_pixel(pix4('h7fff, 0, 'hfffe, 'h7fff));       // widest symmetric window
    pass_pixel(pix4(12, 10, 13, 11));                  // odd width before mirroring

    // min_range sweep: zero acts as one, both extremes, a few in between
    range_plan[0] = 16'h0000;
    range_plan[1] = 16'hffff;
    range_plan[2] = 16'h0002;
    range_plan[3] = 16'h8000;
    range_plan[4] = 16'd300;
    range_plan[5] = 16'($urandom_range(1, FULL));
    range_plan[6] = 16'($urandom_range(1, 4000));
    range_plan[7] = 16'h0001;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pipe(SETTLE_CYCLES);
      set_min_range(range_plan[ph]);
      // last phase runs at full rate on both sides
      quiet = (ph == NUM_PHASES - 1);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        pass_pixel(make_pixel());
        // sender holds off once mid-stream until the pipe is empty
        if (ph == 2 && i == PHASE_PIXELS / 2)
          drain_pipe(0);
      end
    end

    drain_pipe(SETTLE_CYCLES);
    if (tracker.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4800000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
